@@ hw/rtl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character constants and the digit-to-ASCII mapping used by
// the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Default operand width
  localparam int unsigned ValueWidthDefault = 64;

  // Width of the operand field on the input channel
  localparam int unsigned ValueFieldWidth = 64;

  // Base selector codes
  typedef enum logic [1:0] {
    OP_DEC    = 2'd0,
    OP_OCT    = 2'd1,
    OP_HEX_LO = 2'd2,
    OP_HEX_UP = 2'd3
  } op_e;

  // ASCII constants
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharMinus  = 8'h2d;

  // Digits below this value map to '0'..'9'
  localparam logic [3:0] DecRadix = 4'd10;

  // Map one digit value to its ASCII character
  function automatic logic [7:0] digit_to_char(input logic [3:0] d, input logic lower);
    logic [7:0] base_char;
    base_char = lower ? CharLowerA : CharUpperA;
    if (d < DecRadix) begin
      return CharZero + {4'b0000, d};
    end
    return base_char + {4'b0000, d} - {4'b0000, DecRadix};
  endfunction

endpackage

@@ hw/rtl/itoa_if.sv @@
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels of the converter: operand input and character output.
// ----------------------------------------------------------------------------
interface itoa_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [itoa_pkg::ValueFieldWidth-1:0]  value;
  logic                                  is_signed;
  logic [1:0]                            opcode;

  modport source (output valid, output value, output is_signed, output opcode, input ready);
  modport sink   (input valid, input value, input is_signed, input opcode, output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_char;
  logic       last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

@@ hw/rtl/integer_to_ascii_radix.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts an operand to ASCII digits in decimal, octal or hex, most
// significant first, with a leading minus sign for negative signed decimal.
// ----------------------------------------------------------------------------
// Steps: the operand is taken while idle, decimal operands then pass through
//   bit-serial shift-and-add-3, leading zeros are dropped in the skip phase,
//   then the characters are sent, stalling while the output register is full.
// Flow: one item at a time; a new operand is accepted only in idle, after the
//   last character of the previous one has been registered for output.
// Reset: rst_ni clears the controller to idle and the output register empty.
module integer_to_ascii_radix #(
  parameter int unsigned VALUE_WIDTH = itoa_pkg::ValueWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);

  // Digit counts per base
  localparam int unsigned NumDec  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned NumOct  = (VALUE_WIDTH + 2) / 3;
  localparam int unsigned NumHex  = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned DW      = NumDec * 4;
  localparam int unsigned OctBits = NumOct * 3;
  localparam int unsigned HexBits = NumHex * 4;
  localparam int unsigned CW      = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [DW-1:0]          work_q, work_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   oct_q, oct_d;
  logic                   lower_q, lower_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  itoa_pkg::op_e          in_op;
  logic [DW-1:0]          work_adj;
  logic [3:0]             top_digit;
  logic [DW-1:0]          work_shift;
  logic                   out_free;

  // Decode the incoming operand
  assign in_val = in_i.value[VALUE_WIDTH-1:0];
  assign in_op  = itoa_pkg::op_e'(in_i.opcode);
  assign in_neg = (in_op == itoa_pkg::OP_DEC) && in_i.is_signed && in_val[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    work_adj = work_q;
    for (int i = 0; i < int'(NumDec); i++) begin
      if (work_q[i*4 +: 4] >= 4'd5) begin
        work_adj[i*4 +: 4] = work_q[i*4 +: 4] + 4'd3;
      end
    end
  end

  // Select the leading digit and the work register advanced by one digit
  assign top_digit  = oct_q ? {1'b0, work_q[DW-1 -: 3]} : work_q[DW-1 -: 4];
  assign work_shift = oct_q ? (work_q << 3) : (work_q << 4);
  assign out_free   = !out_valid_q || out_o.ready;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last       = out_last_q;

  // Sequence conversion, zero skipping and character output
  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    oct_d       = oct_q;
    lower_d     = lower_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          neg_d   = in_neg;
          lower_d = (in_op == itoa_pkg::OP_HEX_LO);
          oct_d   = (in_op == itoa_pkg::OP_OCT);
          mag_d   = in_mag;
          case (in_op)
            itoa_pkg::OP_DEC: begin
              work_d  = '0;
              cnt_d   = CW'(VALUE_WIDTH);
              state_d = ST_CONV;
            end
            itoa_pkg::OP_OCT: begin
              work_d  = DW'(in_val) << (DW - OctBits);
              cnt_d   = CW'(NumOct);
              state_d = ST_SKIP;
            end
            default: begin
              work_d  = DW'(in_val) << (DW - HexBits);
              cnt_d   = CW'(NumHex);
              state_d = ST_SKIP;
            end
          endcase
        end
      end
      ST_CONV: begin
        // Shift one magnitude bit into the BCD register
        work_d = {work_adj[DW-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d  = mag_q << 1;
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          cnt_d   = CW'(NumDec);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keep at least one digit
        if ((top_digit == 4'd0) && (cnt_q != CW'(1))) begin
          work_d = work_shift;
          cnt_d  = cnt_q - CW'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            out_char_d = itoa_pkg::CharMinus;
            out_last_d = 1'b0;
            neg_d      = 1'b0;
          end else begin
            out_char_d = itoa_pkg::digit_to_char(top_digit, lower_q);
            out_last_d = (cnt_q == CW'(1));
            work_d     = work_shift;
            cnt_d      = cnt_q - CW'(1);
            if (cnt_q == CW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    mag_q      <= mag_d;
    oct_q      <= oct_d;
    lower_q    <= lower_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

`ifndef NO_ASSERTIONS
  // An accepted item leaves idle at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("converter stayed idle after an input transfer");

  // No unfinished character stream while converting the next operand
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !(out_valid_q && !out_last_q))
    else $error("conversion started before the previous stream ended");

  // Digits remain whenever digits are being skipped or sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SKIP) || (state_q == ST_EMIT)) |-> (cnt_q != '0))
    else $error("digit counter ran out before the last character");

  // A minus sign never ends a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_last_q && (out_char_q == itoa_pkg::CharMinus)))
    else $error("minus sign flagged as last character");
`endif

endmodule
